FILE: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

	// Command codes
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// Configuration register indexes
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_HIGH_PERIOD = 1'b1;

	localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
	localparam logic [7:0] HIGH_PERIOD_RST = 8'd2;
	localparam int unsigned BITS_PER_BYTE  = 8;

	typedef struct packed {
		logic [7:0] half_period;
		logic [7:0] high_period;
	} timing_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] wr_byte;
		logic       ack_to_send;
		logic       sda_line;
		logic       scl_line;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_bit;
		logic [7:0] rd_byte;
	} result_t;

endpackage

FILE: rtl/core/i2cm_seq.sv
module i2cm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  i2cm_pkg::item_t    item,
	input  i2cm_pkg::timing_t  timing,
	output i2cm_pkg::result_t  res
);

	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_S_WAIT    = 5'd1,
		PH_S_SCLLO   = 5'd2,
		PH_S_SDAHI   = 5'd3,
		PH_S_SCLHI   = 5'd4,
		PH_S_SDALO   = 5'd5,
		PH_S_END     = 5'd6,
		PH_T_BOTH    = 5'd7,
		PH_T_SDAHI   = 5'd8,
		PH_W_SETUP   = 5'd9,
		PH_W_HIGH    = 5'd10,
		PH_W_ACKSET  = 5'd11,
		PH_W_ACKHIGH = 5'd12,
		PH_R_HIGH    = 5'd13,
		PH_R_LOW     = 5'd14,
		PH_R_ACKSET  = 5'd15,
		PH_R_ACKHIGH = 5'd16
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] tick_q, tick_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] rx_q, rx_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       sda_en_q, sda_en_d;
	logic       nack_q, nack_d;
	logic       ack_q, ack_d;
	logic       done_d;
	logic [7:0] hold_half, hold_high;
	logic [3:0] bit_inc;
	logic [7:0] shift_sl;

	// zero period acts as one
	assign hold_half = (timing.half_period == '0) ? 8'd1 : timing.half_period;
	assign hold_high = (timing.high_period == '0) ? 8'd1 : timing.high_period;
	assign bit_inc   = bit_cnt_q + 4'd1;
	assign shift_sl  = {shift_q[6:0], 1'b0};

	always_comb begin
		phase_d  = phase_q;
		bit_cnt_d = bit_cnt_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		rx_d     = rx_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		sda_en_d = sda_en_q;
		nack_d   = nack_q;
		ack_d    = ack_q;
		done_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			case (item.cmd)
				i2cm_pkg::CMD_START: begin
					sda_en_d = 1'b1;
					phase_d  = PH_S_WAIT;
					tick_d   = hold_half;
				end
				i2cm_pkg::CMD_STOP: begin
					sda_en_d = 1'b1;
					sda_d    = 1'b0;
					scl_d    = 1'b1;
					phase_d  = PH_T_BOTH;
					tick_d   = hold_half;
				end
				i2cm_pkg::CMD_WRITE: begin
					sda_en_d  = 1'b1;
					shift_d   = item.wr_byte;
					bit_cnt_d = '0;
					sda_d     = item.wr_byte[7];
					phase_d   = PH_W_SETUP;
					tick_d    = hold_half;
				end
				i2cm_pkg::CMD_READ: begin
					sda_en_d  = 1'b0;
					nack_d    = item.ack_to_send;
					shift_d   = '0;
					bit_cnt_d = '0;
					scl_d     = 1'b1;
					phase_d   = PH_R_HIGH;
					tick_d    = hold_high;
				end
				default: ;
			endcase
		end else if (tick_q > 8'd1) begin
			tick_d = tick_q - 8'd1;
		end else begin
			case (phase_q)
				PH_S_WAIT: begin
					if (item.scl_line && item.sda_line) begin
						sda_d   = 1'b0;
						phase_d = PH_S_SDALO;
					end else if (item.scl_line) begin
						scl_d   = 1'b0;
						phase_d = PH_S_SCLLO;
					end else if (!item.sda_line) begin
						sda_d   = 1'b1;
						phase_d = PH_S_SDAHI;
					end else begin
						scl_d   = 1'b1;
						phase_d = PH_S_SCLHI;
					end
					tick_d = hold_half;
				end
				PH_S_SCLLO: begin
					// bus recovery: release SDA first if held low
					if (!item.sda_line) begin
						sda_d   = 1'b1;
						phase_d = PH_S_SDAHI;
					end else begin
						scl_d   = 1'b1;
						phase_d = PH_S_SCLHI;
					end
					tick_d = hold_half;
				end
				PH_S_SDAHI: begin
					scl_d = 1'b1; phase_d = PH_S_SCLHI; tick_d = hold_half;
				end
				PH_S_SCLHI: begin
					sda_d = 1'b0; phase_d = PH_S_SDALO; tick_d = hold_half;
				end
				PH_S_SDALO: begin
					scl_d = 1'b0; phase_d = PH_S_END; tick_d = hold_half;
				end
				PH_T_BOTH: begin
					sda_d = 1'b1; phase_d = PH_T_SDAHI; tick_d = hold_half;
				end
				PH_W_SETUP: begin
					scl_d = 1'b1; phase_d = PH_W_HIGH; tick_d = hold_high;
				end
				PH_W_HIGH: begin
					scl_d     = 1'b0;
					shift_d   = shift_sl;
					bit_cnt_d = bit_inc;
					if (bit_inc < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
						sda_d   = shift_sl[7];
						phase_d = PH_W_SETUP;
					end else begin
						phase_d = PH_W_ACKSET;
					end
					tick_d = hold_half;
				end
				PH_W_ACKSET: begin
					sda_en_d = 1'b0;
					scl_d    = 1'b1;
					phase_d  = PH_W_ACKHIGH;
					tick_d   = hold_half;
				end
				PH_W_ACKHIGH: begin
					ack_d   = item.sda_line;
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					tick_d  = '0;
					done_d  = 1'b1;
				end
				PH_R_HIGH: begin
					shift_d   = {shift_q[7:1], shift_q[0] | item.sda_line};
					scl_d     = 1'b0;
					bit_cnt_d = bit_inc;
					phase_d   = PH_R_LOW;
					tick_d    = hold_half;
				end
				PH_R_LOW: begin
					if (bit_cnt_q < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
						shift_d = shift_sl;
						scl_d   = 1'b1;
						phase_d = PH_R_HIGH;
						tick_d  = hold_high;
					end else begin
						rx_d     = shift_q;
						sda_en_d = 1'b1;
						sda_d    = nack_q;
						phase_d  = PH_R_ACKSET;
						tick_d   = hold_half;
					end
				end
				PH_R_ACKSET: begin
					scl_d = 1'b1; phase_d = PH_R_ACKHIGH; tick_d = hold_high;
				end
				PH_R_ACKHIGH: begin
					scl_d   = 1'b0;
					sda_d   = 1'b0;
					phase_d = PH_IDLE;
					tick_d  = '0;
					done_d  = 1'b1;
				end
				default: begin
					// end of start / stop, and unused codes
					phase_d = PH_IDLE;
					tick_d  = '0;
					done_d  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
			rx_q      <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			sda_en_q  <= 1'b1;
			nack_q    <= 1'b0;
			ack_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			tick_q    <= tick_d;
			shift_q   <= shift_d;
			rx_q      <= rx_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			sda_en_q  <= sda_en_d;
			nack_q    <= nack_d;
			ack_q     <= ack_d;
		end
	end

	assign res.scl_out   = scl_d;
	assign res.sda_out   = sda_d;
	assign res.sda_drive = sda_en_d;
	assign res.busy_res  = (phase_d != PH_IDLE);
	assign res.done_res  = done_d;
	assign res.ack_bit   = ack_d;
	assign res.rd_byte   = rx_d;

endmodule

FILE: rtl/core/i2c_master_bit_engine_unit.sv
// Byte-level I2C master sequencer.
// Input channel (in_valid/in_ready): one transaction per bus tick, carrying
// the sampled SCL/SDA pins and, while idle, a command (start, stop, write
// byte, read byte). Commands arriving while a command runs are ignored.
// Output channel (out_valid/out_ready): one transaction per input tick with
// the pin levels, SDA drive enable, busy/done status, write ack bit and the
// last read byte.
// Config port (cfg_we/cfg_idx/cfg_data): index 0 half_period, index 1
// high_period; write only while no tick is in flight.
// Pipeline: an accepted tick sits in the input register and its result is
// loaded into the output register when the sequencer steps, which waits
// while the output stalls. Throughput is one tick per cycle, set by
// the single sequencer update between the two registers, unless stalled.
// A stalled output (out_ready low) holds its result; the input register
// still takes one more tick, then in_ready drops until the output drains.
// Reset: bus idle (SCL/SDA high, SDA driven), both registers empty,
// half_period = 1, high_period = 2.
module i2c_master_bit_engine_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [7:0] wr_byte,
	input  logic       ack_to_send,
	input  logic       sda_line,
	input  logic       scl_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_out,
	output logic       sda_out,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic       ack_bit,
	output logic [7:0] rd_byte,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_data
);

	i2cm_pkg::item_t   item_s1;
	logic              vld_s1;
	i2cm_pkg::timing_t timing_q;
	i2cm_pkg::result_t res_comb, res_q;
	logic              out_vld_q;
	logic              step;

	// sequencer advances when a tick is staged and the output slot frees up
	assign step     = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || step;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.half_period <= i2cm_pkg::HALF_PERIOD_RST;
			timing_q.high_period <= i2cm_pkg::HIGH_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				i2cm_pkg::CFG_HALF_PERIOD: timing_q.half_period <= cfg_data;
				i2cm_pkg::CFG_HIGH_PERIOD: timing_q.high_period <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, wr_byte: wr_byte, ack_to_send: ack_to_send,
				sda_line: sda_line, scl_line: scl_line};
		end
	end

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.timing (timing_q),
		.res    (res_comb)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_comb;
		end
	end

	assign out_valid = out_vld_q;
	assign scl_out   = res_q.scl_out;
	assign sda_out   = res_q.sda_out;
	assign sda_drive = res_q.sda_drive;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign ack_bit   = res_q.ack_bit;
	assign rd_byte   = res_q.rd_byte;

endmodule

FILE: rtl/core/i2cm_checker.sv
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       scl_out,
	input logic       sda_out,
	input logic       sda_drive,
	input logic       busy_res,
	input logic       done_res,
	input logic       ack_bit,
	input logic [7:0] rd_byte
);

	// a finished command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with busy set");

	// input side only backs up behind a stalled output
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl_out) && $stable(sda_out)
		&& $stable(sda_drive) && $stable(busy_res) && $stable(done_res)
		&& $stable(ack_bit) && $stable(rd_byte))
		else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.scl_out   (scl_out),
	.sda_out   (sda_out),
	.sda_drive (sda_drive),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.ack_bit   (ack_bit),
	.rd_byte   (rd_byte)
);
